// ----- rtl/msc_pkg.sv -----
package msc_pkg;

    localparam int unsigned FRAC_BITS_DEF = 8;
    localparam int unsigned NUM_CH        = 7;
    localparam int unsigned W_WIDE        = 32;
    localparam int unsigned W_NARROW      = 16;
    // integer part of any channel: 32-bit unsigned or 16-bit signed fits here
    localparam int unsigned RAW_W         = W_WIDE + 1;

    localparam int unsigned CH_CURRENT  = 0;
    localparam int unsigned CH_VOLTAGE  = 1;
    localparam int unsigned CH_ACTIVE   = 2;
    localparam int unsigned CH_REACTIVE = 3;
    localparam int unsigned CH_APPARENT = 4;
    localparam int unsigned CH_PF       = 5;
    localparam int unsigned CH_FREQ     = 6;

    localparam int unsigned CH_DIV  [NUM_CH] = '{4, 16, 8, 8, 8, 8, 10};
    localparam int unsigned CH_SNAP [NUM_CH] = '{20, 10, 10, 10, 10, 100, 100};
    localparam int unsigned CH_BAND [NUM_CH] = '{10, 5, 5, 5, 5, 50, 50};

    typedef logic signed [RAW_W-1:0] t_raw;

    typedef struct packed {
        logic adv;
        logic first;
        logic commit;
    } t_chan_ctl;

endpackage

// ----- rtl/msc_if.sv -----
interface msc_rdg_if;
    logic                                 valid;
    logic                                 ready;
    logic [msc_pkg::W_WIDE-1:0]           raw_current;
    logic [msc_pkg::W_NARROW-1:0]         raw_voltage;
    logic [msc_pkg::W_WIDE-1:0]           raw_active;
    logic [msc_pkg::W_WIDE-1:0]           raw_reactive;
    logic [msc_pkg::W_WIDE-1:0]           raw_apparent;
    logic signed [msc_pkg::W_NARROW-1:0]  raw_pf;
    logic [msc_pkg::W_NARROW-1:0]         raw_freq;
    logic [msc_pkg::W_NARROW-1:0]         alarm_bits;
    logic [msc_pkg::W_NARROW-1:0]         status_bits;
    logic [msc_pkg::W_WIDE-1:0]           gap_ms;

    modport source (
        output valid, raw_current, raw_voltage, raw_active, raw_reactive,
               raw_apparent, raw_pf, raw_freq, alarm_bits, status_bits, gap_ms,
        input  ready
    );
    modport sink (
        input  valid, raw_current, raw_voltage, raw_active, raw_reactive,
               raw_apparent, raw_pf, raw_freq, alarm_bits, status_bits, gap_ms,
        output ready
    );
endinterface

interface msc_rep_if;
    logic                                 valid;
    logic                                 ready;
    logic [msc_pkg::W_WIDE-1:0]           rep_current;
    logic [msc_pkg::W_NARROW-1:0]         rep_voltage;
    logic [msc_pkg::W_WIDE-1:0]           rep_active;
    logic [msc_pkg::W_WIDE-1:0]           rep_reactive;
    logic [msc_pkg::W_WIDE-1:0]           rep_apparent;
    logic signed [msc_pkg::W_NARROW-1:0]  rep_pf;
    logic [msc_pkg::W_NARROW-1:0]         rep_freq;
    logic [msc_pkg::W_NARROW-1:0]         rep_alarm;
    logic [msc_pkg::W_NARROW-1:0]         rep_status;
    logic [msc_pkg::W_WIDE-1:0]           rep_gap_ms;

    modport source (
        output valid, rep_current, rep_voltage, rep_active, rep_reactive,
               rep_apparent, rep_pf, rep_freq, rep_alarm, rep_status, rep_gap_ms,
        input  ready
    );
    modport sink (
        input  valid, rep_current, rep_voltage, rep_active, rep_reactive,
               rep_apparent, rep_pf, rep_freq, rep_alarm, rep_status, rep_gap_ms,
        output ready
    );
endinterface

// ----- rtl/msc_chan.sv -----
module msc_chan #(
    parameter int unsigned FRAC_BITS = msc_pkg::FRAC_BITS_DEF,
    parameter int unsigned CH        = msc_pkg::CH_CURRENT
) (
    input  logic               i_clk,
    input  msc_pkg::t_raw      i_raw,
    input  msc_pkg::t_chan_ctl i_ctl,
    output msc_pkg::t_raw      o_int,
    output logic               o_over
);

    localparam int unsigned SW    = msc_pkg::RAW_W + FRAC_BITS;
    localparam int unsigned DIV   = msc_pkg::CH_DIV[CH];
    localparam int unsigned SNAP  = msc_pkg::CH_SNAP[CH];
    localparam int unsigned BAND  = msc_pkg::CH_BAND[CH];
    // below the snap limit the difference magnitude fits in MW bits
    localparam int unsigned MW    = FRAC_BITS + $clog2(SNAP + 1);
    localparam int unsigned DSH   = $clog2(DIV);
    localparam int unsigned SHR   = MW + DSH;
    localparam int unsigned RCP   = (2 ** SHR) / DIV + 1;
    localparam bit          POW2  = ((DIV & (DIV - 1)) == 0);
    localparam int unsigned RW    = msc_pkg::RAW_W;

    logic signed [SW-1:0] r_smooth;
    logic signed [SW-1:0] n_smooth;
    logic signed [SW-1:0] raw_fx;
    logic signed [SW:0]   diff;
    logic [SW:0]          mag;
    logic [MW-1:0]        mag_n;
    logic [MW-1:0]        quo;
    logic signed [SW-1:0] quo_s;
    logic                 snap;

    logic [SW-1:0]        s_mag;
    logic [SW-1:0]        s_ipart;
    msc_pkg::t_raw        cur_int;
    msc_pkg::t_raw        r_last;
    logic signed [RW:0]   bdiff;
    logic [RW:0]          bmag;

    // smoothing step
    assign raw_fx = SW'(i_raw) <<< FRAC_BITS;
    assign diff   = (SW + 1)'(raw_fx) - (SW + 1)'(r_smooth);
    assign mag    = diff[SW] ? (SW + 1)'(-diff) : (SW + 1)'(diff);
    assign snap   = (mag >> FRAC_BITS) > (SW + 1)'(SNAP);
    assign mag_n  = mag[MW-1:0];

    generate
        if (POW2) begin : g_shift
            assign quo = mag_n >> DSH;
        end else begin : g_recip
            localparam logic [MW:0] RCP_C = (MW + 1)'(RCP);
            logic [2*MW:0] prod;
            assign prod = (2 * MW + 1)'(mag_n) * (2 * MW + 1)'(RCP_C);
            assign quo  = MW'(prod >> SHR);
        end
    endgenerate

    assign quo_s = SW'(quo);

    always_comb begin
        priority if (i_ctl.first || snap) begin
            n_smooth = raw_fx;
        end else if (diff[SW]) begin
            n_smooth = r_smooth - quo_s;
        end else begin
            n_smooth = r_smooth + quo_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_smooth <= n_smooth;
        end
    end

    // integer part, truncated toward zero
    assign s_mag   = r_smooth[SW-1] ? SW'(-r_smooth) : SW'(r_smooth);
    assign s_ipart = s_mag >> FRAC_BITS;
    assign cur_int = r_smooth[SW-1] ? -RW'(s_ipart) : RW'(s_ipart);
    assign o_int   = cur_int;

    // deadband against the last reported value
    assign bdiff  = (RW + 1)'(r_last) - (RW + 1)'(cur_int);
    assign bmag   = bdiff[RW] ? (RW + 1)'(-bdiff) : (RW + 1)'(bdiff);
    assign o_over = bmag > (RW + 1)'(BAND);

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_last <= cur_int;
        end
    end

endmodule

// ----- rtl/meter_smoothing_change_reporter_core.sv -----
// channel  | role   | word
// i_rdg    | sink   | one meter reading: seven raw channels, flag/status words, gap
// o_rep    | source | one report: seven integer parts, flag/status words, gap
//
// one reading accepted per cycle unless upstream is stalled; its report leaves through the stages below
// stages: input register, channel filters (state update), report decision/output register
// readings that cause no report are dropped at the decision stage without a bubble
// synchronous active-low reset empties all stages and forgets the first reading
// a stalled report holds in the output register; upstream stalls only when all stages are full
module meter_smoothing_change_reporter_core #(
    parameter int unsigned FRAC_BITS = msc_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msc_rdg_if.sink     i_rdg,
    msc_rep_if.source   o_rep
);

    typedef struct packed {
        logic [msc_pkg::W_WIDE-1:0]          raw_current;
        logic [msc_pkg::W_NARROW-1:0]        raw_voltage;
        logic [msc_pkg::W_WIDE-1:0]          raw_active;
        logic [msc_pkg::W_WIDE-1:0]          raw_reactive;
        logic [msc_pkg::W_WIDE-1:0]          raw_apparent;
        logic [msc_pkg::W_NARROW-1:0]        raw_pf;
        logic [msc_pkg::W_NARROW-1:0]        raw_freq;
        logic [msc_pkg::W_NARROW-1:0]        alarm_bits;
        logic [msc_pkg::W_NARROW-1:0]        status_bits;
        logic [msc_pkg::W_WIDE-1:0]          gap_ms;
    } t_rdg_word;

    typedef struct packed {
        logic [msc_pkg::W_NARROW-1:0]        alarm;
        logic [msc_pkg::W_NARROW-1:0]        status;
        logic [msc_pkg::W_WIDE-1:0]          gap;
    } t_side_word;

    typedef struct packed {
        logic [msc_pkg::W_WIDE-1:0]          current;
        logic [msc_pkg::W_NARROW-1:0]        voltage;
        logic [msc_pkg::W_WIDE-1:0]          active;
        logic [msc_pkg::W_WIDE-1:0]          reactive;
        logic [msc_pkg::W_WIDE-1:0]          apparent;
        logic [msc_pkg::W_NARROW-1:0]        pf;
        logic [msc_pkg::W_NARROW-1:0]        freq;
        logic [msc_pkg::W_NARROW-1:0]        alarm;
        logic [msc_pkg::W_NARROW-1:0]        status;
        logic [msc_pkg::W_WIDE-1:0]          gap;
    } t_rep_word;

    localparam int unsigned RW = msc_pkg::RAW_W;

    logic                r_in_vld;
    t_rdg_word           r_in;
    logic                r_s1_vld;
    logic                r_s1_first;
    t_side_word          r_s1;
    logic                r_out_vld;
    t_rep_word           r_out;
    logic                r_primed;
    logic [msc_pkg::W_NARROW-1:0] r_last_alarm;
    logic [msc_pkg::W_NARROW-1:0] r_last_status;

    logic                in_rdy;
    logic                adv0;
    logic                adv1;
    logic                out_free;
    logic                report;
    msc_pkg::t_chan_ctl  ctl;
    msc_pkg::t_raw       raw_ch [msc_pkg::NUM_CH];
    msc_pkg::t_raw       int_ch [msc_pkg::NUM_CH];
    logic [msc_pkg::NUM_CH-1:0] over;

    // pipeline flow
    assign out_free = !r_out_vld || o_rep.ready;
    assign adv1     = r_s1_vld && (!report || out_free);
    assign adv0     = r_in_vld && (!r_s1_vld || adv1);
    assign in_rdy   = !r_in_vld || adv0;
    assign i_rdg.ready = in_rdy;

    assign report = r_s1_first || (|over)
                    || (r_s1.alarm != r_last_alarm)
                    || (r_s1.status != r_last_status);

    assign ctl.adv    = adv0;
    assign ctl.first  = !r_primed;
    assign ctl.commit = adv1 && report;

    // raw channels widened to a common signed width
    assign raw_ch[msc_pkg::CH_CURRENT]  = RW'(r_in.raw_current);
    assign raw_ch[msc_pkg::CH_VOLTAGE]  = RW'(r_in.raw_voltage);
    assign raw_ch[msc_pkg::CH_ACTIVE]   = RW'(r_in.raw_active);
    assign raw_ch[msc_pkg::CH_REACTIVE] = RW'(r_in.raw_reactive);
    assign raw_ch[msc_pkg::CH_APPARENT] = RW'(r_in.raw_apparent);
    assign raw_ch[msc_pkg::CH_PF]       = RW'($signed(r_in.raw_pf));
    assign raw_ch[msc_pkg::CH_FREQ]     = RW'(r_in.raw_freq);

    generate
        for (genvar g = 0; g < msc_pkg::NUM_CH; g++) begin : g_ch
            msc_chan #(
                .FRAC_BITS (FRAC_BITS),
                .CH        (g)
            ) u_chan (
                .i_clk  (i_clk),
                .i_raw  (raw_ch[g]),
                .i_ctl  (ctl),
                .o_int  (int_ch[g]),
                .o_over (over[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_primed  <= 1'b0;
        end else begin
            if (i_rdg.valid && in_rdy) begin
                r_in_vld <= 1'b1;
            end else if (adv0) begin
                r_in_vld <= 1'b0;
            end
            if (adv0) begin
                r_s1_vld <= 1'b1;
                r_primed <= 1'b1;
            end else if (adv1) begin
                r_s1_vld <= 1'b0;
            end
            if (adv1 && report) begin
                r_out_vld <= 1'b1;
            end else if (o_rep.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_rdg.valid && in_rdy) begin
            r_in.raw_current  <= i_rdg.raw_current;
            r_in.raw_voltage  <= i_rdg.raw_voltage;
            r_in.raw_active   <= i_rdg.raw_active;
            r_in.raw_reactive <= i_rdg.raw_reactive;
            r_in.raw_apparent <= i_rdg.raw_apparent;
            r_in.raw_pf       <= i_rdg.raw_pf;
            r_in.raw_freq     <= i_rdg.raw_freq;
            r_in.alarm_bits   <= i_rdg.alarm_bits;
            r_in.status_bits  <= i_rdg.status_bits;
            r_in.gap_ms       <= i_rdg.gap_ms;
        end
        if (adv0) begin
            r_s1_first <= !r_primed;
            r_s1.alarm  <= r_in.alarm_bits;
            r_s1.status <= r_in.status_bits;
            r_s1.gap    <= r_in.gap_ms;
        end
        if (adv1 && report) begin
            r_last_alarm   <= r_s1.alarm;
            r_last_status  <= r_s1.status;
            r_out.current  <= int_ch[msc_pkg::CH_CURRENT][msc_pkg::W_WIDE-1:0];
            r_out.voltage  <= int_ch[msc_pkg::CH_VOLTAGE][msc_pkg::W_NARROW-1:0];
            r_out.active   <= int_ch[msc_pkg::CH_ACTIVE][msc_pkg::W_WIDE-1:0];
            r_out.reactive <= int_ch[msc_pkg::CH_REACTIVE][msc_pkg::W_WIDE-1:0];
            r_out.apparent <= int_ch[msc_pkg::CH_APPARENT][msc_pkg::W_WIDE-1:0];
            r_out.pf       <= int_ch[msc_pkg::CH_PF][msc_pkg::W_NARROW-1:0];
            r_out.freq     <= int_ch[msc_pkg::CH_FREQ][msc_pkg::W_NARROW-1:0];
            r_out.alarm    <= r_s1.alarm;
            r_out.status   <= r_s1.status;
            r_out.gap      <= r_s1.gap;
        end
    end

    assign o_rep.valid        = r_out_vld;
    assign o_rep.rep_current  = r_out.current;
    assign o_rep.rep_voltage  = r_out.voltage;
    assign o_rep.rep_active   = r_out.active;
    assign o_rep.rep_reactive = r_out.reactive;
    assign o_rep.rep_apparent = r_out.apparent;
    assign o_rep.rep_pf       = $signed(r_out.pf);
    assign o_rep.rep_freq     = r_out.freq;
    assign o_rep.rep_alarm    = r_out.alarm;
    assign o_rep.rep_status   = r_out.status;
    assign o_rep.rep_gap_ms   = r_out.gap;

    // nothing past the input register before the first reading has entered the filters
    a_unprimed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_primed |-> (!r_s1_vld && !r_out_vld))
        else $error("stage occupied before first reading");

    a_first_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && r_s1_first) |=> r_out_vld)
        else $error("first reading did not report");

    a_last_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && report) |=> (r_last_alarm == o_rep.rep_alarm
                              && r_last_status == o_rep.rep_status))
        else $error("reported words and change reference disagree");

endmodule
